// ----- rtl/core/dcw_pkg.sv -----
package dcw_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned DUTY_BITS = 8;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned SPEED_EXT_W = 2 * DUTY_BITS + SPEED_W;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [CMD_W-1:0] CHAR_F       = 8'h46;
  localparam logic [CMD_W-1:0] CHAR_B       = 8'h42;
  localparam logic [CMD_W-1:0] CHAR_L       = 8'h4C;
  localparam logic [CMD_W-1:0] CHAR_R       = 8'h52;
  localparam logic [CMD_W-1:0] CHAR_S       = 8'h53;
  localparam logic [CMD_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CMD_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CMD_W-1:0] CASE_OFFSET  = 8'h20;

  localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [MS_W-1:0] TIMEOUT_RESET  = 16'd1000;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FORWARD  = 3'd0,
    REG_BACKWARD = 3'd1,
    REG_LEFT     = 3'd2,
    REG_RIGHT    = 3'd3,
    REG_DEBOUNCE = 3'd4,
    REG_TIMEOUT  = 3'd5,
    REG_SAFETY   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [CMD_W-1:0] cmd_byte;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    dir_e                 dir_a;
    logic [DUTY_BITS-1:0] duty_a;
    dir_e                 dir_b;
    logic [DUTY_BITS-1:0] duty_b;
    logic                 timed_out;
  } out_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] forward_speeds;
    logic [SPEED_W-1:0] backward_speeds;
    logic [SPEED_W-1:0] left_speeds;
    logic [SPEED_W-1:0] right_speeds;
    logic [MS_W-1:0]    debounce_ms;
    logic [MS_W-1:0]    timeout_ms;
    logic               safety_enable;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_now;
    logic [TIME_BITS-1:0] last_accept_time;
    logic [CMD_W-1:0]     last_command;
    logic [TIME_BITS-1:0] last_motion_time;
    dir_e                 motor_a_dir;
    logic [DUTY_BITS-1:0] motor_a_duty;
    dir_e                 motor_b_dir;
    logic [DUTY_BITS-1:0] motor_b_duty;
  } state_t;

  function automatic logic [DUTY_BITS-1:0] duty_of_a(logic [SPEED_W-1:0] speeds);
    logic [SPEED_EXT_W-1:0] ext;
    ext = SPEED_EXT_W'(speeds);
    return ext[DUTY_BITS-1:0];
  endfunction

  function automatic logic [DUTY_BITS-1:0] duty_of_b(logic [SPEED_W-1:0] speeds);
    logic [SPEED_EXT_W-1:0] ext;
    ext = SPEED_EXT_W'(speeds);
    return ext[2*DUTY_BITS-1:DUTY_BITS];
  endfunction

endpackage

// ----- rtl/core/dcw_step.sv -----
module dcw_step import dcw_pkg::*; (
  input  cfg_t      cfg_i,
  input  state_t    state_i,
  input  in_item_t  item_i,
  output state_t    state_o,
  output out_item_t result_o
);

  logic [CMD_W-1:0]     cmd_upper;
  logic [TIME_BITS-1:0] time_inc;
  logic [TIME_BITS-1:0] since_motion;
  logic [TIME_BITS-1:0] since_accept;
  logic                 moving;
  logic                 expired;
  logic                 absorbed;

  always_comb begin
    if (item_i.cmd_byte >= CHAR_LOWER_A && item_i.cmd_byte <= CHAR_LOWER_Z) begin
      cmd_upper = item_i.cmd_byte - CASE_OFFSET;
    end else begin
      cmd_upper = item_i.cmd_byte;
    end
  end

  assign time_inc     = state_i.time_now + TIME_BITS'(1);
  assign since_motion = time_inc - state_i.last_motion_time;
  assign since_accept = state_i.time_now - state_i.last_accept_time;
  assign moving       = (state_i.motor_a_dir != DIR_STOP) || (state_i.motor_b_dir != DIR_STOP);
  assign expired      = cfg_i.safety_enable && moving &&
                        (state_i.last_motion_time != '0) &&
                        (since_motion > TIME_BITS'(cfg_i.timeout_ms));
  assign absorbed     = (since_accept < TIME_BITS'(cfg_i.debounce_ms)) &&
                        (cmd_upper == state_i.last_command) && (cmd_upper != CHAR_S);

  always_comb begin
    state_o            = state_i;
    result_o.accepted  = 1'b0;
    result_o.timed_out = 1'b0;
    unique case (item_i.op)
      OP_TICK: begin
        state_o.time_now = time_inc;
        if (expired) begin
          state_o.motor_a_dir      = DIR_STOP;
          state_o.motor_a_duty     = '0;
          state_o.motor_b_dir      = DIR_STOP;
          state_o.motor_b_duty     = '0;
          state_o.last_motion_time = '0;
          result_o.timed_out       = 1'b1;
        end
      end
      OP_CMD: begin
        result_o.accepted = 1'b1;
        if (absorbed) begin
          state_o.last_motion_time = state_i.time_now;
        end else begin
          state_o.last_accept_time = state_i.time_now;
          state_o.last_command     = cmd_upper;
          unique case (cmd_upper)
            CHAR_F: begin
              state_o.motor_a_dir      = DIR_FWD;
              state_o.motor_b_dir      = DIR_FWD;
              state_o.motor_a_duty     = duty_of_a(cfg_i.forward_speeds);
              state_o.motor_b_duty     = duty_of_b(cfg_i.forward_speeds);
              state_o.last_motion_time = state_i.time_now;
            end
            CHAR_B: begin
              state_o.motor_a_dir      = DIR_BWD;
              state_o.motor_b_dir      = DIR_BWD;
              state_o.motor_a_duty     = duty_of_a(cfg_i.backward_speeds);
              state_o.motor_b_duty     = duty_of_b(cfg_i.backward_speeds);
              state_o.last_motion_time = state_i.time_now;
            end
            CHAR_L: begin
              state_o.motor_a_dir      = DIR_BWD;
              state_o.motor_b_dir      = DIR_FWD;
              state_o.motor_a_duty     = duty_of_a(cfg_i.left_speeds);
              state_o.motor_b_duty     = duty_of_b(cfg_i.left_speeds);
              state_o.last_motion_time = state_i.time_now;
            end
            CHAR_R: begin
              state_o.motor_a_dir      = DIR_FWD;
              state_o.motor_b_dir      = DIR_BWD;
              state_o.motor_a_duty     = duty_of_a(cfg_i.right_speeds);
              state_o.motor_b_duty     = duty_of_b(cfg_i.right_speeds);
              state_o.last_motion_time = state_i.time_now;
            end
            CHAR_S: begin
              state_o.motor_a_dir  = DIR_STOP;
              state_o.motor_b_dir  = DIR_STOP;
              state_o.motor_a_duty = '0;
              state_o.motor_b_duty = '0;
            end
            default: begin
              state_o.motor_a_dir  = DIR_STOP;
              state_o.motor_b_dir  = DIR_STOP;
              state_o.motor_a_duty = '0;
              state_o.motor_b_duty = '0;
              result_o.accepted    = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.dir_a  = state_o.motor_a_dir;
    result_o.duty_a = state_o.motor_a_duty;
    result_o.dir_b  = state_o.motor_b_dir;
    result_o.duty_b = state_o.motor_b_duty;
  end

endmodule

// ----- rtl/core/drive_command_decoder_watchdog.sv -----
// Two-motor drive decoder: each input item is either a command byte (F, B, L, R, S, case
// insensitive) or a one-millisecond tick, and each item produces exactly one result item
// giving both motor directions and duties after that item. The block takes one item per
// clock cycle while the output is not stalled; each item is held in the input register,
// then its result is loaded into the result register, from which it is offered. While a
// result waits, the input register holds one further item before the input side stalls.
// Speeds, the debounce window, the watchdog timeout and the watchdog enable are set through
// the APB port, one 32-bit register per word, and should be written only while no item is
// in flight.
module drive_command_decoder_watchdog import dcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg_q, cfg_d;
  state_t    state_q, state_d;
  state_t    state_next;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t result_d, result_q;
  logic      result_valid_q;
  logic      advance;
  logic      cfg_write;
  reg_idx_e  reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_FORWARD:  cfg_d.forward_speeds  = pwdata[SPEED_W-1:0];
        REG_BACKWARD: cfg_d.backward_speeds = pwdata[SPEED_W-1:0];
        REG_LEFT:     cfg_d.left_speeds     = pwdata[SPEED_W-1:0];
        REG_RIGHT:    cfg_d.right_speeds    = pwdata[SPEED_W-1:0];
        REG_DEBOUNCE: cfg_d.debounce_ms     = pwdata[MS_W-1:0];
        REG_TIMEOUT:  cfg_d.timeout_ms      = pwdata[MS_W-1:0];
        REG_SAFETY:   cfg_d.safety_enable   = pwdata[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORWARD:  prdata = APB_DATA_W'(cfg_q.forward_speeds);
      REG_BACKWARD: prdata = APB_DATA_W'(cfg_q.backward_speeds);
      REG_LEFT:     prdata = APB_DATA_W'(cfg_q.left_speeds);
      REG_RIGHT:    prdata = APB_DATA_W'(cfg_q.right_speeds);
      REG_DEBOUNCE: prdata = APB_DATA_W'(cfg_q.debounce_ms);
      REG_TIMEOUT:  prdata = APB_DATA_W'(cfg_q.timeout_ms);
      REG_SAFETY:   prdata = APB_DATA_W'(cfg_q.safety_enable);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_speeds  <= '0;
      cfg_q.backward_speeds <= '0;
      cfg_q.left_speeds     <= '0;
      cfg_q.right_speeds    <= '0;
      cfg_q.debounce_ms     <= DEBOUNCE_RESET;
      cfg_q.timeout_ms      <= TIMEOUT_RESET;
      cfg_q.safety_enable   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance     = item_valid_q && (!result_valid_q || out_ready_i);
  assign in_ready_o  = !item_valid_q || advance;
  assign out_valid_o = result_valid_q;
  assign out_item_o  = result_q;

  dcw_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_next),
    .result_o (result_d)
  );

  assign state_d = advance ? state_next : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= '0;
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        result_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        result_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

endmodule

// ----- rtl/core/dcw_checker.sv -----
module dcw_checker import dcw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o,
  input logic      pready
);

  a_stopped_a_no_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.dir_a == DIR_STOP) |-> (out_item_o.duty_a == '0))
    else $error("Motor A is stopped but reports a duty.");

  a_stopped_b_no_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.dir_b == DIR_STOP) |-> (out_item_o.duty_b == '0))
    else $error("Motor B is stopped but reports a duty.");

  a_timeout_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.timed_out |->
      !out_item_o.accepted && (out_item_o.dir_a == DIR_STOP) && (out_item_o.dir_b == DIR_STOP))
    else $error("A watchdog timeout left a motor running or flagged a command.");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("A stalled result item changed or was withdrawn.");

  a_pready_high : assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("The register port inserted a wait state.");

endmodule

bind drive_command_decoder_watchdog dcw_checker u_dcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);
